FILE: rtl/core/dual_ultrasonic_ranger_assert.svh
// Assertion macros used by the ranger checker.
`ifndef DUAL_ULTRASONIC_RANGER_ASSERT_SVH
`define DUAL_ULTRASONIC_RANGER_ASSERT_SVH

// Check that a condition implies a consequence on the same edge.
`define DUR_ASSERT_IMPLY(label, clk, off, cond, cons) \
  label: assert property (@(posedge clk) disable iff (off) (cond) |-> (cons)) \
    else $error("ranger check failed: same-cycle implication");

// Check that a condition implies a consequence on the next edge.
`define DUR_ASSERT_NEXT(label, clk, off, cond, cons) \
  label: assert property (@(posedge clk) disable iff (off) (cond) |=> (cons)) \
    else $error("ranger check failed: next-cycle implication");

`endif

FILE: rtl/core/dur_pkg.sv
// Package with payload types and register constants for the ultrasonic ranger.
`default_nettype none
package dur_pkg;

  typedef struct packed {
    logic echo_first;
    logic echo_second;
  } echo_t;

  typedef struct packed {
    logic       trig_first;
    logic       trig_second;
    logic       reading_done;
    logic       in_range;
    logic       sensor_id;
    logic [9:0] distance_cm;
  } result_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE        = 3'd4;

  localparam logic [7:0]  RST_TRIGGER_LOW  = 8'd2;
  localparam logic [7:0]  RST_TRIGGER_HIGH = 8'd20;
  localparam logic [7:0]  RST_US_PER_CM    = 8'd58;
  localparam logic [9:0]  RST_MAX_RANGE    = 10'd400;
  localparam logic [19:0] RST_PAUSE        = 20'd500000;

  localparam logic [9:0] CM_MAX = 10'd1023;

endpackage
`default_nettype wire

FILE: rtl/core/dur_core.sv
// Ranging sequencer: configuration registers, phase state and per-tick result logic.
`default_nettype none
module dur_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dur_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           step,
  input  wire dur_pkg::echo_t                 echo,
  output dur_pkg::result_t                    result
);
  import dur_pkg::*;

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_PAUSE     = 3'd4
  } phase_t;

  logic [7:0]  trigger_low_us;
  logic [7:0]  trigger_high_us;
  logic [7:0]  us_per_cm;
  logic [9:0]  max_range_cm;
  logic [19:0] pause_us;

  phase_t      phase, phase_next;
  logic [19:0] phase_timer, phase_timer_next;
  logic [7:0]  sub_cm_ticks, sub_cm_ticks_next;
  logic [9:0]  cm_count, cm_count_next;
  logic        active_sensor, active_sensor_next;

  logic        echo_sel;
  logic        trig;
  logic        done;
  logic [9:0]  reading_cm;
  logic [19:0] timer_base;
  logic [20:0] timer_inc;
  logic [7:0]  base_sub;
  logic [9:0]  base_cm;
  logic [8:0]  sub_inc;
  logic        cm_wrap;
  logic [7:0]  cnt_sub;
  logic [9:0]  cnt_cm;

  function automatic logic ends_at(input logic [20:0] t_inc, input logic [19:0] len);
    logic [20:0] len_eff;
    len_eff = (len == 20'd0) ? 21'd1 : {1'b0, len};
    return t_inc >= len_eff;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_low_us  <= RST_TRIGGER_LOW;
      trigger_high_us <= RST_TRIGGER_HIGH;
      us_per_cm       <= RST_US_PER_CM;
      max_range_cm    <= RST_MAX_RANGE;
      pause_us        <= RST_PAUSE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_LOW:  trigger_low_us  <= cfg_data[7:0];
        CFG_TRIGGER_HIGH: trigger_high_us <= cfg_data[7:0];
        CFG_US_PER_CM:    us_per_cm       <= cfg_data[7:0];
        CFG_MAX_RANGE:    max_range_cm    <= cfg_data[9:0];
        CFG_PAUSE:        pause_us        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign echo_sel   = active_sensor ? echo.echo_second : echo.echo_first;
  assign timer_base = (phase == PH_TRIG_LOW || phase == PH_TRIG_HIGH || phase == PH_PAUSE)
                      ? phase_timer : 20'd0;
  assign timer_inc  = {1'b0, timer_base} + 21'd1;

  // restart the centimetre count on the first echo tick
  assign base_sub = (phase == PH_MEASURE) ? sub_cm_ticks : 8'd0;
  assign base_cm  = (phase == PH_MEASURE) ? cm_count : 10'd0;
  assign sub_inc  = {1'b0, base_sub} + 9'd1;
  assign cm_wrap  = sub_inc >= {1'b0, us_per_cm};
  assign cnt_sub  = cm_wrap ? 8'd0 : sub_inc[7:0];
  assign cnt_cm   = (cm_wrap && base_cm != CM_MAX) ? base_cm + 10'd1 : base_cm;

  always_comb begin
    phase_next         = phase;
    phase_timer_next   = phase_timer;
    sub_cm_ticks_next  = sub_cm_ticks;
    cm_count_next      = cm_count;
    active_sensor_next = active_sensor;
    trig               = 1'b0;
    done               = 1'b0;
    reading_cm         = 10'd0;
    case (phase)
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        if (ends_at(timer_inc, {12'd0, trigger_high_us})) begin
          phase_next       = PH_WAIT_RISE;
          phase_timer_next = 20'd0;
        end else begin
          phase_timer_next = timer_inc[19:0];
        end
      end
      PH_WAIT_RISE: begin
        if (echo_sel) begin
          sub_cm_ticks_next = cnt_sub;
          cm_count_next     = cnt_cm;
          phase_next        = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (echo_sel) begin
          sub_cm_ticks_next = cnt_sub;
          cm_count_next     = cnt_cm;
        end else begin
          done             = 1'b1;
          reading_cm       = cm_count;
          phase_next       = PH_PAUSE;
          phase_timer_next = 20'd0;
        end
      end
      PH_PAUSE: begin
        if (ends_at(timer_inc, pause_us)) begin
          phase_next         = PH_TRIG_LOW;
          phase_timer_next   = 20'd0;
          active_sensor_next = ~active_sensor;
        end else begin
          phase_timer_next = timer_inc[19:0];
        end
      end
      default: begin
        if (ends_at(timer_inc, {12'd0, trigger_low_us})) begin
          phase_next       = PH_TRIG_HIGH;
          phase_timer_next = 20'd0;
        end else begin
          phase_next       = PH_TRIG_LOW;
          phase_timer_next = timer_inc[19:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TRIG_LOW;
      phase_timer   <= 20'd0;
      sub_cm_ticks  <= 8'd0;
      cm_count      <= 10'd0;
      active_sensor <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      phase_timer   <= phase_timer_next;
      sub_cm_ticks  <= sub_cm_ticks_next;
      cm_count      <= cm_count_next;
      active_sensor <= active_sensor_next;
    end
  end

  always_comb begin
    result.trig_first   = trig & ~active_sensor;
    result.trig_second  = trig & active_sensor;
    result.reading_done = done;
    result.in_range     = done & (reading_cm < max_range_cm);
    result.sensor_id    = active_sensor;
    result.distance_cm  = reading_cm;
  end

endmodule
`default_nettype wire

FILE: rtl/core/dual_ultrasonic_ranger.sv
// A tick request goes to the input register; its phase update is done in a single pass into
// the result register. Throughput: one tick request per cycle while the skid entry is empty.
// A result register and one skid entry hold results while the output stalls; the input
// stops once both of them and the input register are full.
// Reset: synchronous, active high; clears pipeline valids, phase state and
// loads the default configuration registers.
`default_nettype none
module dual_ultrasonic_ranger (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           echo_valid,
  output logic                                echo_ready,
  input  wire dur_pkg::echo_t                 echo,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output dur_pkg::result_t                    result,
  input  wire logic                           cfg_we,
  input  wire logic [dur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dur_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dur_pkg::*;

  logic    stage_valid;
  echo_t   stage_echo;
  logic    advance;
  result_t step_result;
  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign advance    = stage_valid & ~skid_valid;
  assign echo_ready = ~stage_valid | advance;
  assign pop        = result_valid & result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (echo_ready) begin
      stage_valid <= echo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (echo_ready && echo_valid) begin
      stage_echo <= echo;
    end
  end

  dur_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .echo      (stage_echo),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= advance;
      end
    end else if (advance) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || pop) begin
      result <= skid_valid ? skid : step_result;
    end else if (advance) begin
      skid <= step_result;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dur_checker.sv
// Port-level checker for the ultrasonic ranger, bound to the top level.
`default_nettype none
`include "dual_ultrasonic_ranger_assert.svh"
module dur_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             echo_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire dur_pkg::result_t result
);
  import dur_pkg::*;

  logic hold_req;
  logic trig_any;
  logic trig_owner_ok;
  logic report_ok;

  assign hold_req      = result_valid & ~result_ready;
  assign trig_any      = result_valid & (result.trig_first | result.trig_second);
  assign trig_owner_ok = (result.trig_first ^ result.trig_second) &
                         (result.sensor_id == result.trig_second);
  assign report_ok     = result.reading_done ? ~(result.trig_first | result.trig_second)
                         : (~result.in_range & (result.distance_cm == 10'd0));

  `DUR_ASSERT_NEXT(a_result_hold, clk, rst, hold_req, result_valid && $stable(result))
  `DUR_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, echo_ready && !result_valid)
  `DUR_ASSERT_IMPLY(a_trig_owner, clk, rst, trig_any, trig_owner_ok)
  `DUR_ASSERT_IMPLY(a_report_fields, clk, rst, result_valid, report_ok)

endmodule

bind dual_ultrasonic_ranger dur_checker u_dur_checker (
  .clk          (clk),
  .rst          (rst),
  .echo_ready   (echo_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire

FILE: bench/dual_ultrasonic_ranger_tb.sv
// Self-checking testbench for the dual ultrasonic ranger: directed script, random ticks.
`timescale 1ns / 100ps

module dual_ultrasonic_ranger_tb;
  import dur_pkg::*;

  typedef enum logic [2:0] {
    PH_LOW,
    PH_HIGH,
    PH_WAIT,
    PH_MEASURE,
    PH_PAUSE
  } ranger_phase_e;

  typedef struct packed {
    logic                  do_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    echo_t                 e;
    logic                  typed;
    result_t               want;
  } script_row_t;

  localparam echo_t E_NONE   = '{1'b0, 1'b0};
  localparam echo_t E_FIRST  = '{1'b1, 1'b0};
  localparam echo_t E_SECOND = '{1'b0, 1'b1};
  localparam echo_t E_BOTH   = '{1'b1, 1'b1};

  localparam result_t R_QUIET = '0;
  localparam result_t R_TRIG0 = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0};
  localparam result_t R_DIST2 = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 10'd2};
  localparam result_t R_DIST1 = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 10'd1};

  localparam int SCRIPT_LEN = 25;
  localparam int RANDOM_TICKS = 1850;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_NONE,   1'b1, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_BOTH,   1'b1, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_NONE,   1'b1, R_TRIG0},
    '{1'b1, CFG_TRIGGER_HIGH, 20'd1,       E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_US_PER_CM,    20'd1,       E_SECOND, 1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_FIRST,  1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_BOTH,   1'b0, R_QUIET},
    '{1'b1, CFG_MAX_RANGE,    20'd2,       E_SECOND, 1'b1, R_DIST2},
    '{1'b1, CFG_PAUSE,        20'd0,       E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_TRIGGER_LOW,  20'd0,       E_BOTH,   1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_US_PER_CM,    20'd0,       E_SECOND, 1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_SECOND, 1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_BOTH,   1'b0, R_QUIET},
    '{1'b1, CFG_MAX_RANGE,    20'd1023,    E_FIRST,  1'b0, R_QUIET},
    '{1'b1, CFG_PAUSE,        20'hFFFFF,   E_NONE,   1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_BOTH,   1'b0, R_QUIET},
    '{1'b1, CFG_PAUSE,        20'd2,       E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_TRIGGER_LOW,  20'd255,     E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_TRIGGER_LOW,  20'd1,       E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_TRIGGER_HIGH, 20'd255,     E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_TRIGGER_HIGH, 20'd1,       E_NONE,   1'b0, R_QUIET},
    '{1'b1, CFG_MAX_RANGE,    20'd0,       E_FIRST,  1'b0, R_QUIET},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_NONE,   1'b1, R_DIST1},
    '{1'b0, CFG_TRIGGER_LOW,  20'd0,       E_NONE,   1'b0, R_QUIET}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  echo_valid = 1'b0;
  logic                  echo_ready;
  echo_t                 echo = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic idle_in = 1'b1;
  logic idle_out = 1'b1;
  int   mismatches = 0;
  result_t pending_results [$];

  // shadow registers and ranger state
  logic [7:0]    low_us = RST_TRIGGER_LOW;
  logic [7:0]    high_us = RST_TRIGGER_HIGH;
  logic [7:0]    ticks_per_cm = RST_US_PER_CM;
  logic [9:0]    range_cm = RST_MAX_RANGE;
  logic [19:0]   pause_len = RST_PAUSE;
  ranger_phase_e ph = PH_LOW;
  int unsigned   ph_timer = 0;
  int unsigned   sub_ticks = 0;
  int unsigned   cm_cnt = 0;
  logic          act_sensor = 1'b0;

  int unsigned burst_left = 0;
  logic        want_sat = 1'b0;

  dual_ultrasonic_ranger u_dut (
    .clk          (clk),
    .rst          (rst),
    .echo_valid   (echo_valid),
    .echo_ready   (echo_ready),
    .echo         (echo),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic timer_done(int unsigned len);
    return ph_timer + 1 >= ((len == 0) ? 1 : len);
  endfunction

  task automatic count_cm();
    if (sub_ticks + 1 >= ticks_per_cm) begin
      sub_ticks = 0;
      if (cm_cnt < CM_MAX) cm_cnt++;
    end else begin
      sub_ticks = (sub_ticks + 1) & 8'hFF;
    end
  endtask

  task automatic ranger_step(input echo_t e, output result_t r);
    logic lvl;
    logic trig;
    lvl = act_sensor ? e.echo_second : e.echo_first;
    trig = 1'b0;
    r = '0;
    r.sensor_id = act_sensor;
    case (ph)
      PH_HIGH: begin
        trig = 1'b1;
        if (timer_done(high_us)) begin
          ph = PH_WAIT;
          ph_timer = 0;
        end else begin
          ph_timer++;
        end
      end
      PH_WAIT: begin
        if (lvl) begin
          sub_ticks = 0;
          cm_cnt = 0;
          count_cm();
          ph = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (lvl) begin
          count_cm();
        end else begin
          r.reading_done = 1'b1;
          r.distance_cm = cm_cnt[9:0];
          r.in_range = (cm_cnt < range_cm);
          ph = PH_PAUSE;
          ph_timer = 0;
        end
      end
      PH_PAUSE: begin
        if (timer_done(pause_len)) begin
          ph = PH_LOW;
          ph_timer = 0;
          act_sensor = ~act_sensor;
        end else begin
          ph_timer = (ph_timer + 1) & 20'hFFFFF;
        end
      end
      default: begin
        if (timer_done(low_us)) begin
          ph = PH_HIGH;
          ph_timer = 0;
        end else begin
          ph_timer++;
        end
      end
    endcase
    r.trig_first = trig & ~r.sensor_id;
    r.trig_second = trig & r.sensor_id;
  endtask

  // shape echoes: rise after a short wait, hold for a burst, rare glitches
  function automatic echo_t make_echo();
    echo_t e;
    logic  lvl;
    e = echo_t'(2'($urandom_range(0, 3)));
    case (ph)
      PH_WAIT:    lvl = ($urandom_range(0, 3) == 0);
      PH_MEASURE: lvl = (burst_left != 0);
      default:    lvl = 1'($urandom_range(0, 1));
    endcase
    if (burst_left < 64 && $urandom_range(0, 24) == 0) lvl = ~lvl;
    if (ph == PH_WAIT && lvl) begin
      if (want_sat) begin
        burst_left = $urandom_range(1030, 1060);
        want_sat = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(60, 300);
      end else begin
        burst_left = $urandom_range(1, 60);
      end
      burst_left--;
    end else if (ph == PH_MEASURE && burst_left != 0) begin
      burst_left--;
    end
    if (act_sensor) e.echo_second = lvl;
    else e.echo_first = lvl;
    return e;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result expected none got %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    cmp_field("trig_first", 10'(want.trig_first), 10'(got.trig_first));
    cmp_field("trig_second", 10'(want.trig_second), 10'(got.trig_second));
    cmp_field("reading_done", 10'(want.reading_done), 10'(got.reading_done));
    cmp_field("in_range", 10'(want.in_range), 10'(got.in_range));
    cmp_field("sensor_id", 10'(want.sensor_id), 10'(got.sensor_id));
    cmp_field("distance_cm", want.distance_cm, got.distance_cm);
  endtask

  task automatic send_tick(input echo_t e, input logic typed, input result_t want);
    int      gap;
    result_t model;
    gap = idle_in ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      echo_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    echo_valid <= 1'b1;
    echo <= e;
    do @(posedge clk); while (echo_ready !== 1'b1);
    ranger_step(e, model);
    pending_results.push_back(typed ? want : model);
  endtask

  task automatic settle();
    @(negedge clk);
    echo_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TRIGGER_LOW:  low_us = val[7:0];
      CFG_TRIGGER_HIGH: high_us = val[7:0];
      CFG_US_PER_CM:    ticks_per_cm = val[7:0];
      CFG_MAX_RANGE:    range_cm = val[9:0];
      CFG_PAUSE:        pause_len = val[19:0];
      default: ;
    endcase
  endtask

  initial begin
    int stall;
    forever begin
      stall = idle_out ? $urandom_range(0, 12) : 0;
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (rst || result_valid !== 1'b1);
      check_result(result);
    end
  end

  initial begin
    #2000000;
    $display("dual_ultrasonic_ranger_tb failed");
    $finish;
  end

  initial begin
    int                    k;
    int                    span;
    int                    random_sent;
    logic [CFG_DATA_W-1:0] val;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].do_cfg) begin
        settle();
        set_reg(SCRIPT[i].idx, SCRIPT[i].val);
      end
      send_tick(SCRIPT[i].e, SCRIPT[i].typed, SCRIPT[i].want);
    end

    k = 0;
    random_sent = 0;
    while (random_sent < RANDOM_TICKS) begin
      settle();
      idle_in = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      if (k == 0) begin
        // one long echo at one tick per cm drives the distance into saturation
        set_reg(CFG_TRIGGER_LOW, CFG_DATA_W'(1));
        set_reg(CFG_TRIGGER_HIGH, CFG_DATA_W'(1));
        set_reg(CFG_US_PER_CM, CFG_DATA_W'(1));
        set_reg(CFG_MAX_RANGE, CFG_DATA_W'(1023));
        set_reg(CFG_PAUSE, '0);
        want_sat = 1'b1;
        span = 1150;
      end else begin
        set_reg(CFG_TRIGGER_LOW, pick_duration());
        set_reg(CFG_TRIGGER_HIGH, pick_duration());
        case ($urandom_range(0, 5))
          0:       val = '0;
          1:       val = CFG_DATA_W'(255);
          2:       val = CFG_DATA_W'($urandom_range(1, 255));
          default: val = CFG_DATA_W'($urandom_range(1, 4));
        endcase
        set_reg(CFG_US_PER_CM, val);
        case ($urandom_range(0, 3))
          0:       val = '0;
          1:       val = CFG_DATA_W'(1023);
          2:       val = CFG_DATA_W'($urandom_range(0, 1023));
          default: val = CFG_DATA_W'($urandom_range(0, 40));
        endcase
        set_reg(CFG_MAX_RANGE, val);
        case ($urandom_range(0, 3))
          0:       val = '0;
          1:       val = CFG_DATA_W'(1);
          default: val = CFG_DATA_W'($urandom_range(2, 30));
        endcase
        set_reg(CFG_PAUSE, val);
        span = $urandom_range(60, 160);
      end
      repeat (span) begin
        send_tick(make_echo(), 1'b0, R_QUIET);
        random_sent++;
      end
      k++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("dual_ultrasonic_ranger_tb passed");
    end else begin
      $display("dual_ultrasonic_ranger_tb failed");
    end
    $finish;
  end

endmodule
